### src/kvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg: shared definitions for the key/value translation table
// Field widths, opcode, command kind, status and mode codes, and the control
// word that travels from the front end to the engine.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF      = 64;
    localparam int VALUE_BITS_DEF    = 64;

    // Stream and register widths
    localparam int FIELD_W    = 64;
    localparam int S_TDATA_W  = 256;
    localparam int M_TDATA_W  = 64;
    localparam int CODE_W     = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Command queue between front end and engine
    localparam int QUEUE_DEPTH = 2;

    // Input opcodes
    localparam logic [CODE_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [CODE_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [CODE_W-1:0] OP_XLATE = 2'd2;

    // Classified command kinds
    localparam logic [CODE_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [CODE_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [CODE_W-1:0] KIND_XLATE = 2'd2;
    localparam logic [CODE_W-1:0] KIND_NOP   = 2'd3;

    // Result status codes
    localparam logic [CODE_W-1:0] ST_DONE   = 2'd0;
    localparam logic [CODE_W-1:0] ST_MISS   = 2'd1;
    localparam logic [CODE_W-1:0] ST_STRICT = 2'd2;
    localparam logic [CODE_W-1:0] ST_FULL   = 2'd3;

    // Miss handling modes
    localparam logic [CODE_W-1:0] MODE_PASS   = 2'd0;
    localparam logic [CODE_W-1:0] MODE_STRICT = 2'd1;
    localparam logic [CODE_W-1:0] MODE_SOURCE = 2'd2;

    // Register index of miss_mode
    localparam logic [0:0] REG_MISS_MODE = 1'b0;

    typedef struct packed {
        logic [CODE_W-1:0] kind;
        logic              last;
    } cmd_ctrl_t;

endpackage

### src/key_value_translation_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_translation_table: stream key/value translator
// Clears, loads or translates one element per input word, with a
// configurable policy for keys that are not in the table.
// ----------------------------------------------------------------------------
// Input words enter a two-deep command queue and are carried out one at a
// time by the engine, which searches the key memory one entry per cycle,
// while the output register is free, through its single registered read
// port. A clear or an unused opcode is finished by the engine straight from
// idle. A load or a translate scans the entries in order until the key is
// found or the entry count is reached (a full table holds 64 entries). Results
// leave through an output register, and the queue keeps taking words while
// a result waits. The table memories are not cleared after reset; only
// entries below the entry count are ever read. miss_mode (byte address 0)
// selects the miss policy: 0 or 3 pass the key through, 1 flag an error,
// 2 return source_value.
module key_value_translation_table #(
    parameter int TABLE_ENTRIES = kvt_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS    = kvt_pkg::VALUE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kvt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kvt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kvt_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_key [63:0], entry_value [127:64], match_key [191:128],
    // source_value [255:192]
    input  logic [kvt_pkg::S_TDATA_W-1:0]  s_tdata,
    // op [1:0]
    input  logic [kvt_pkg::CODE_W-1:0]     s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_value [63:0]
    output logic [kvt_pkg::M_TDATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [kvt_pkg::CODE_W-1:0]     m_tuser,
    output logic                           m_tlast
);
    import kvt_pkg::*;

    logic [CODE_W-1:0]     miss_mode_reg;
    logic                  cfg_write;
    logic                  sel_miss_mode;

    logic                  q_valid;
    cmd_ctrl_t             q_ctrl;
    logic [KEY_BITS-1:0]   q_key;
    logic [VALUE_BITS-1:0] q_value;
    logic                  q_pop;

    // Registers are word addressed; the two low address bits are ignored.
    assign sel_miss_mode = (paddr[APB_ADDR_W-1:2] == REG_MISS_MODE);
    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite && pready;
    assign prdata        = sel_miss_mode ? APB_DATA_W'(miss_mode_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            miss_mode_reg <= MODE_PASS;
        end else if (cfg_write && sel_miss_mode) begin
            miss_mode_reg <= pwdata[CODE_W-1:0];
        end
    end

    kvt_front #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ctrl   (q_ctrl),
        .q_key    (q_key),
        .q_value  (q_value),
        .q_pop    (q_pop)
    );

    kvt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .miss_mode (miss_mode_reg),
        .q_valid   (q_valid),
        .q_ctrl    (q_ctrl),
        .q_key     (q_key),
        .q_value   (q_value),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### src/kvt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_front: input front end and command queue
// Accepts input words, classifies the opcode, picks the key and value that
// the command needs, and holds the result in a short queue for the engine.
// ----------------------------------------------------------------------------
module kvt_front #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_key [63:0], entry_value [127:64], match_key [191:128],
    // source_value [255:192]
    input  logic [kvt_pkg::S_TDATA_W-1:0] s_tdata,
    // op [1:0]
    input  logic [kvt_pkg::CODE_W-1:0]    s_tuser,
    input  logic                          s_tlast,
    output logic                          q_valid,
    output kvt_pkg::cmd_ctrl_t            q_ctrl,
    output logic [KEY_BITS-1:0]           q_key,
    output logic [VALUE_BITS-1:0]         q_value,
    input  logic                          q_pop
);
    import kvt_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_ctrl_t             ctrl_q_reg [QUEUE_DEPTH];
    logic [KEY_BITS-1:0]   key_q_reg  [QUEUE_DEPTH];
    logic [VALUE_BITS-1:0] val_q_reg  [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;

    cmd_ctrl_t             in_ctrl;
    logic [FIELD_W-1:0]    sel_key;
    logic [FIELD_W-1:0]    sel_value;
    logic                  push;
    logic                  pop;

    assign s_tready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;

    // A load carries its entry pair, a translate its match key and fallback.
    always_comb begin
        in_ctrl.last = s_tlast;
        sel_key      = s_tdata[FIELD_W-1:0];
        sel_value    = s_tdata[2*FIELD_W-1:FIELD_W];
        case (s_tuser)
            OP_CLEAR: begin
                in_ctrl.kind = KIND_CLEAR;
            end
            OP_LOAD: begin
                in_ctrl.kind = KIND_LOAD;
            end
            OP_XLATE: begin
                in_ctrl.kind = KIND_XLATE;
                sel_key      = s_tdata[3*FIELD_W-1:2*FIELD_W];
                sel_value    = s_tdata[4*FIELD_W-1:3*FIELD_W];
            end
            default: begin
                in_ctrl.kind = KIND_NOP;
            end
        endcase
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ctrl_q_reg[wr_ptr_reg] <= in_ctrl;
            key_q_reg[wr_ptr_reg]  <= sel_key[KEY_BITS-1:0];
            val_q_reg[wr_ptr_reg]  <= sel_value[VALUE_BITS-1:0];
        end
    end

    assign q_ctrl  = ctrl_q_reg[rd_ptr_reg];
    assign q_key   = key_q_reg[rd_ptr_reg];
    assign q_value = val_q_reg[rd_ptr_reg];

endmodule

### src/kvt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_engine: table storage, key search and result register
// Takes queued commands, scans the key memory one entry per cycle while the
// output is free, updates the table and presents one result word per command.
// ----------------------------------------------------------------------------
module kvt_engine #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 64,
    parameter int VALUE_BITS    = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [kvt_pkg::CODE_W-1:0]    miss_mode,
    input  logic                          q_valid,
    input  kvt_pkg::cmd_ctrl_t            q_ctrl,
    input  logic [KEY_BITS-1:0]           q_key,
    input  logic [VALUE_BITS-1:0]         q_value,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_value [63:0]
    output logic [kvt_pkg::M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [kvt_pkg::CODE_W-1:0]    m_tuser,
    output logic                          m_tlast
);
    import kvt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic [KEY_BITS-1:0]   key_mem [TABLE_ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [TABLE_ENTRIES];

    logic                  state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic [KEY_BITS-1:0]   key_rd_reg;
    logic [VALUE_BITS-1:0] val_rd_reg;

    logic [CODE_W-1:0]     cmd_kind_reg;
    logic                  cmd_last_reg;
    logic [KEY_BITS-1:0]   cmd_key_reg;
    logic [VALUE_BITS-1:0] cmd_val_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic [CODE_W-1:0]     m_status_reg;
    logic                  m_last_reg;

    logic                  out_free;
    logic                  start;
    logic                  hit;
    logic                  scan_end;
    logic                  issue;
    logic                  out_load;
    logic [M_TDATA_W-1:0]  res_value;
    logic [CODE_W-1:0]     res_status;
    logic                  res_last;
    logic                  key_we;
    logic                  val_we;
    logic [IDX_W-1:0]      wr_addr;

    assign out_free = !m_valid_reg || m_tready;
    assign start    = (state_reg == S_IDLE) && q_valid && out_free;
    assign q_pop    = start;

    // The read data registered by the last issued read is compared against the command key.
    assign hit      = pend_reg && (key_rd_reg == cmd_key_reg);
    assign scan_end = hit || (rd_idx_reg == count_reg);
    assign issue    = (state_reg == S_SCAN) && out_free && !scan_end;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        pend_next   = pend_reg;
        out_load    = 1'b0;
        res_value   = '0;
        res_status  = ST_DONE;
        res_last    = cmd_last_reg;
        key_we      = 1'b0;
        val_we      = 1'b0;
        wr_addr     = count_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    res_last = q_ctrl.last;
                    case (q_ctrl.kind)
                        KIND_CLEAR: begin
                            count_next = '0;
                            out_load   = 1'b1;
                        end
                        KIND_LOAD, KIND_XLATE: begin
                            rd_idx_next = '0;
                            pend_next   = 1'b0;
                            state_next  = S_SCAN;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (out_free) begin
                    pend_next = issue;
                    if (issue) begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                    if (scan_end) begin
                        state_next = S_IDLE;
                        out_load   = 1'b1;
                        if (cmd_kind_reg == KIND_LOAD) begin
                            if (hit) begin
                                val_we  = 1'b1;
                                wr_addr = cmp_idx_reg;
                            end else if (count_reg != CNT_W'(TABLE_ENTRIES)) begin
                                key_we     = 1'b1;
                                val_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                res_status = ST_FULL;
                            end
                        end else if (hit) begin
                            res_value = M_TDATA_W'(val_rd_reg);
                        end else begin
                            case (miss_mode)
                                MODE_STRICT: begin
                                    res_status = ST_STRICT;
                                end
                                MODE_SOURCE: begin
                                    res_value  = M_TDATA_W'(cmd_val_reg);
                                    res_status = ST_MISS;
                                end
                                default: begin
                                    res_value  = M_TDATA_W'(cmd_key_reg);
                                    res_status = ST_MISS;
                                end
                            endcase
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cmd_kind_reg <= q_ctrl.kind;
            cmd_last_reg <= q_ctrl.last;
            cmd_key_reg  <= q_key;
            cmd_val_reg  <= q_value;
        end
        if (out_load) begin
            m_data_reg   <= res_value;
            m_status_reg <= res_status;
            m_last_reg   <= res_last;
        end
    end

    // Table memories: one write port, one registered read port each.
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= cmd_key_reg;
        end
        if (issue) begin
            key_rd_reg <= key_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[wr_addr] <= cmd_val_reg;
        end
        if (issue) begin
            val_rd_reg  <= val_mem[rd_idx_reg[IDX_W-1:0]];
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (rd_idx_reg <= count_reg))
        else $error("scan index past entry count");

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_reg)
        else $error("compare pending while idle");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && (q_ctrl.kind == KIND_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the table");

endmodule

### tb/tb_key_value_translation_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_value_translation_table: self-checking bench for the translation table
// A table of directed words covers the empty, hit, miss, replace, clear and
// unused-opcode cases across all miss modes. Random episodes follow, each loading
// a small table (a few fill it to overflow) and translating a stream of keys.
// Every accepted word is run through a local model of the table, and results
// are compared in order, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_key_value_translation_table;
    import kvt_pkg::*;

    localparam int RANDOM_WORDS = 1200;
    localparam int MAX_GAP      = 6;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;

    localparam logic [CODE_W-1:0]     OP_NONE       = 2'd3;
    localparam logic [CODE_W-1:0]     MODE_ALT_PASS = 2'd3;
    localparam logic [63:0]           ONES          = '1;
    localparam logic [APB_ADDR_W-1:0] MISS_MODE_ADDR = APB_ADDR_W'(4 * REG_MISS_MODE);

    typedef struct packed {
        logic [63:0]       value;
        logic [CODE_W-1:0] status;
        logic              last;
    } table_result_t;

    typedef struct packed {
        logic [CODE_W-1:0] mode;
        logic [CODE_W-1:0] op;
        logic [63:0]       ekey;
        logic [63:0]       eval;
        logic [63:0]       mkey;
        logic [63:0]       sval;
        logic              last;
        logic              typed;
        logic [63:0]       exp_value;
        logic [CODE_W-1:0] exp_status;
    } vector_row_t;

    // Rows whose typed flag is clear are checked against the local model only.
    localparam vector_row_t DIRECTED [20] = '{
        '{MODE_PASS, OP_XLATE, 64'h0, ONES, 64'h0, ONES, 1'b0, 1'b1, 64'h0, ST_MISS},
        '{MODE_PASS, OP_XLATE, 64'h0, 64'h0, ONES, 64'h0, 1'b1, 1'b1, ONES, ST_MISS},
        '{MODE_PASS, OP_LOAD, 64'h0, ONES, ONES, ONES, 1'b0, 1'b1, 64'h0, ST_DONE},
        '{MODE_PASS, OP_LOAD, ONES, 64'h0, 64'h0, ONES, 1'b0, 1'b1, 64'h0, ST_DONE},
        '{MODE_PASS, OP_XLATE, ONES, 64'h0, 64'h0, 64'h0, 1'b0, 1'b1, ONES, ST_DONE},
        '{MODE_PASS, OP_XLATE, 64'h0, ONES, ONES, ONES, 1'b1, 1'b1, 64'h0, ST_DONE},
        '{MODE_PASS, OP_LOAD, 64'h0, 64'h5555_5555_5555_5555, 64'h0, 64'h0,
          1'b0, 1'b0, 64'h0, ST_DONE},
        '{MODE_PASS, OP_XLATE, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0, ST_DONE},
        '{MODE_PASS, OP_NONE, ONES, ONES, ONES, ONES, 1'b1, 1'b1, 64'h0, ST_DONE},
        '{MODE_STRICT, OP_XLATE, 64'h0, 64'h0, 64'h1234, ONES, 1'b0, 1'b1, 64'h0, ST_STRICT},
        '{MODE_STRICT, OP_XLATE, 64'h0, 64'h0, ONES, 64'h0, 1'b1, 1'b0, 64'h0, ST_DONE},
        '{MODE_SOURCE, OP_XLATE, 64'h0, 64'h0, 64'h8000_0000_0000_0000, ONES,
          1'b0, 1'b1, ONES, ST_MISS},
        '{MODE_SOURCE, OP_XLATE, ONES, ONES, 64'h1, 64'h0, 1'b1, 1'b1, 64'h0, ST_MISS},
        '{MODE_SOURCE, OP_XLATE, 64'h0, 64'h0, 64'h0, 64'h0123_4567_89AB_CDEF,
          1'b0, 1'b0, 64'h0, ST_DONE},
        '{MODE_ALT_PASS, OP_XLATE, 64'h0, 64'h0, 64'hDEAD_BEEF_0BAD_F00D, ONES,
          1'b0, 1'b1, 64'hDEAD_BEEF_0BAD_F00D, ST_MISS},
        '{MODE_ALT_PASS, OP_CLEAR, ONES, ONES, ONES, ONES, 1'b1, 1'b1, 64'h0, ST_DONE},
        '{MODE_ALT_PASS, OP_XLATE, 64'h0, 64'h0, 64'h0, ONES, 1'b0, 1'b1, 64'h0, ST_MISS},
        '{MODE_PASS, OP_LOAD, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE, 64'h0,
          64'h0, 1'b0, 1'b0, 64'h0, ST_DONE},
        '{MODE_PASS, OP_XLATE, 64'h0, 64'h0, 64'h8000_0000_0000_0001, 64'h0,
          1'b1, 1'b0, 64'h0, ST_DONE},
        '{MODE_PASS, OP_CLEAR, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 1'b1, 64'h0, ST_DONE}
    };

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [CODE_W-1:0]     s_tuser  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [CODE_W-1:0]     m_tuser;
    logic                  m_tlast;

    key_value_translation_table DUT (.*);

    always #1 aclk = ~aclk;

    // Local copy of the table and the miss policy.
    logic [63:0]       key_tbl [TABLE_ENTRIES_DEF];
    logic [63:0]       val_tbl [TABLE_ENTRIES_DEF];
    int                tbl_count   = 0;
    logic [CODE_W-1:0] mode_shadow = MODE_PASS;

    table_result_t pending_q [$];
    int            fail_count  = 0;
    int            cycle_count = 0;
    int            random_words = 0;
    bit            hold_armed  = 1'b0;
    bit            hold_done   = 1'b0;
    bit            no_idle     = 1'b0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_key();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return ONES;
            default: return rand64();
        endcase
    endfunction

    function automatic table_result_t apply_word(input logic [CODE_W-1:0] op,
                                                 input logic [63:0] ekey, eval, mkey, sval,
                                                 input logic last);
        table_result_t r;
        logic [63:0]   k;
        int            slot;
        r    = '{value: 64'h0, status: ST_DONE, last: last};
        k    = (op == OP_LOAD) ? ekey : mkey;
        slot = -1;
        for (int i = 0; i < tbl_count; i++) begin
            if (slot < 0 && key_tbl[i] == k) slot = i;
        end
        case (op)
            OP_CLEAR: tbl_count = 0;
            OP_LOAD: begin
                if (slot >= 0) begin
                    val_tbl[slot] = eval;
                end else if (tbl_count < TABLE_ENTRIES_DEF) begin
                    key_tbl[tbl_count] = ekey;
                    val_tbl[tbl_count] = eval;
                    tbl_count++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_XLATE: begin
                if (slot >= 0) begin
                    r.value = val_tbl[slot];
                end else if (mode_shadow == MODE_STRICT) begin
                    r.status = ST_STRICT;
                end else if (mode_shadow == MODE_SOURCE) begin
                    r.value  = sval;
                    r.status = ST_MISS;
                end else begin
                    r.value  = mkey;
                    r.status = ST_MISS;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(input logic [CODE_W-1:0] op,
                             input logic [63:0] ekey, eval, mkey, sval,
                             input logic last, input logic typed,
                             input table_result_t typed_res);
        int            gap;
        table_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {sval, mkey, eval, ekey};
        s_tuser  <= op;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = apply_word(op, ekey, eval, mkey, sval, last);
        pending_q.push_back(typed ? typed_res : predicted);
    endtask

    // Waits for the table to go idle, writes the mode and reads it back.
    task automatic write_miss_mode(input logic [CODE_W-1:0] m);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MISS_MODE_ADDR;
        pwdata  <= APB_DATA_W'(m);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        mode_shadow = m;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(m)) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("miss_mode readback: expected %0d, got %0d", m, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off so the input backs up.
    initial begin : result_ready
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            if (hold_armed && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : result_check
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result word: value %h status %0d last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = pending_q.pop_front();
                if (m_tdata !== want.value || m_tuser !== want.status ||
                    m_tlast !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("result word: expected %h/%0d/%b, got %h/%0d/%b",
                                 want.value, want.status, want.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        vector_row_t   row;
        table_result_t typed_res;
        logic [63:0]   k;
        logic [63:0]   ep_keys [$];
        logic          last;
        bit            full_ep;
        int            n_load;
        int            n_xlate;
        int            ep;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(DIRECTED); i++) begin
            row = DIRECTED[i];
            if (row.mode != mode_shadow) write_miss_mode(row.mode);
            typed_res = '{value: row.exp_value, status: row.exp_status, last: row.last};
            send_word(row.op, row.ekey, row.eval, row.mkey, row.sval, row.last,
                      row.typed, typed_res);
        end

        // Each episode loads a table and then streams elements through it.
        ep = 0;
        while (random_words < RANDOM_WORDS) begin
            if (ep < 4 || $urandom_range(0, 1) == 1)
                write_miss_mode(ep < 4 ? CODE_W'(ep) : CODE_W'($urandom_range(0, 3)));
            no_idle = ($urandom_range(0, 4) == 0);
            full_ep = (ep % 10 == 3);
            ep_keys.delete();
            if (full_ep || $urandom_range(0, 5) != 0) begin
                send_word(OP_CLEAR, rand64(), rand64(), rand64(), rand64(),
                          1'($urandom_range(0, 1)), 1'b0, '0);
                random_words++;
            end
            n_load = full_ep ? TABLE_ENTRIES_DEF + $urandom_range(2, 6) : $urandom_range(1, 12);
            for (int j = 0; j < n_load; j++) begin
                if (full_ep) begin
                    // Past the table size, odd loads are new keys and must be refused.
                    if (j < TABLE_ENTRIES_DEF || j % 2 == 1)
                        k = rand64();
                    else
                        k = ep_keys[$urandom_range(0, ep_keys.size() - 1)];
                end else if (ep_keys.size() != 0 && $urandom_range(0, 3) == 0) begin
                    k = ep_keys[$urandom_range(0, ep_keys.size() - 1)];
                end else begin
                    k = rand_key();
                end
                ep_keys.push_back(k);
                send_word(OP_LOAD, k, rand64(), rand64(), rand64(),
                          1'($urandom_range(0, 1)), 1'b0, '0);
                random_words++;
            end
            n_xlate = $urandom_range(4, 24);
            for (int j = 0; j < n_xlate; j++) begin
                last = (j == n_xlate - 1) || ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 11) == 0) begin
                    send_word(CODE_W'($urandom_range(0, 3)), rand_key(), rand64(),
                              rand_key(), rand64(), last, 1'b0, '0);
                end else begin
                    if ($urandom_range(0, 2) != 0)
                        k = ep_keys[$urandom_range(0, ep_keys.size() - 1)];
                    else
                        k = rand_key();
                    send_word(OP_XLATE, rand64(), rand64(), k, rand64(), last, 1'b0, '0);
                end
                random_words++;
                if (random_words >= HOLD_AFTER) hold_armed = 1'b1;
            end
            ep++;
        end

        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### key_value_translation_table.f
src/kvt_pkg.sv
src/kvt_front.sv
src/kvt_engine.sv
src/key_value_translation_table.sv
tb/tb_key_value_translation_table.sv
